>>> rtl/rdac_pkg.sv
// Shared constants, select codes and decode tables of the palette DAC register interface.
package rdac_pkg;

   // Register select codes; selects 0, 1 and 3 always go to the palette.
   localparam logic [2:0] SEL_HIDDEN          = 3'd2;
   localparam logic [2:0] SEL_PLL_WRITE_INDEX = 3'd4;
   localparam logic [2:0] SEL_PLL_DATA        = 3'd5;
   localparam logic [2:0] SEL_COMMAND         = 3'd6;
   localparam logic [2:0] SEL_PLL_READ_INDEX  = 3'd7;

   // CSR indexes
   localparam logic CSR_CHIP_VARIANT = 1'b0;
   localparam logic CSR_VENDOR_ID    = 1'b1;

   // Hidden unlock counter values
   localparam logic [2:0] UNLOCK_ONE   = 3'd1;
   localparam logic [2:0] UNLOCK_TWO   = 3'd2;
   localparam logic [2:0] UNLOCK_THREE = 3'd3;
   localparam logic [2:0] UNLOCK_OPEN  = 3'd4;

   localparam logic [7:0]  VENDOR_BYTE    = 8'h70;
   localparam logic [7:0]  WRITE_RESPONSE = 8'hff;
   localparam logic [15:0] PLL_WORD0_INIT = 16'h6128;
   localparam logic [15:0] PLL_WORD1_INIT = 16'h623d;

   localparam logic [2:0] VARIANT_LAST_THREE_BIT = 3'd1;
   localparam logic [2:0] VARIANT_LAST_KNOWN     = 3'd4;

   // Depth codes: 0=8, 1=15, 2=16, 3=24, 4=32 bpp
   localparam logic [2:0] DEPTH_THREE [8] = '{3'd0, 3'd1, 3'd3, 3'd2, 3'd1, 3'd1, 3'd2, 3'd3};
   localparam logic [2:0] DEPTH_FOUR [16] = '{3'd0, 3'd0, 3'd1, 3'd1, 3'd3, 3'd2, 3'd2, 3'd4,
                                              3'd1, 3'd3, 3'd1, 3'd0, 3'd2, 3'd0, 3'd3, 3'd0};

   // Only eight PLL words are writable: 2..7, 0x0a, 0x0e.
   function automatic logic pll_writable(input logic [7:0] index);
      return ((index >= 8'd2) && (index <= 8'd7)) || (index == 8'h0a) || (index == 8'h0e);
   endfunction

   // Storage slot of a writable PLL word.
   function automatic logic [2:0] pll_slot(input logic [7:0] index);
      logic [2:0] slot;
      case (index)
         8'h0a:   slot = 3'd6;
         8'h0e:   slot = 3'd7;
         default: slot = index[2:0] - 3'd2;
      endcase
      return slot;
   endfunction

   // Power-up value of a PLL word.
   function automatic logic [15:0] pll_reset_word(input logic [7:0] index);
      logic [15:0] word;
      case (index)
         8'h00:   word = PLL_WORD0_INIT;
         8'h01:   word = PLL_WORD1_INIT;
         default: word = 16'h0000;
      endcase
      return word;
   endfunction

   function automatic logic [2:0] depth_decode(input logic [2:0] variant,
                                               input logic [7:0] cmd,
                                               input logic [2:0] old_depth);
      logic [2:0] depth;
      if (variant <= VARIANT_LAST_THREE_BIT) begin
         depth = DEPTH_THREE[cmd[7:5]];
      end else if (variant <= VARIANT_LAST_KNOWN) begin
         depth = DEPTH_FOUR[cmd[7:4]];
      end else begin
         depth = old_depth;
      end
      return depth;
   endfunction

endpackage

>>> rtl/rdac_pll_store.sv
// PLL register file: 8-entry synchronous memory for the writable words plus reset constants.
module rdac_pll_store (
   input  logic        clock,
   input  logic        reset,
   input  logic        rd_en,
   input  logic [7:0]  rd_index,
   input  logic        wr_en,
   input  logic [7:0]  wr_index,
   input  logic [15:0] wr_data,
   output logic [15:0] rd_word
);
   import rdac_pkg::*;

   logic [15:0] mem [8];
   logic [7:0]  valid_ff;
   logic [15:0] rd_data_ff;
   logic [15:0] rd_const_ff;
   logic        rd_hit_ff;
   logic        wr_ok;
   logic [2:0]  wr_slot;
   logic [2:0]  rd_slot;

   assign wr_ok   = wr_en && pll_writable(wr_index);
   assign wr_slot = pll_slot(wr_index);
   assign rd_slot = pll_slot(rd_index);

   always_ff @(posedge clock) begin
      if (wr_ok) begin
         mem[wr_slot] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff  <= mem[rd_slot];
         rd_const_ff <= pll_reset_word(rd_index);
      end
   end

   // an unwritten slot reads as its reset value (zero)
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= '0;
         rd_hit_ff <= 1'b0;
      end else begin
         if (wr_ok) begin
            valid_ff[wr_slot] <= 1'b1;
         end
         if (rd_en) begin
            rd_hit_ff <= pll_writable(rd_index) && valid_ff[rd_slot];
         end
      end
   end

   assign rd_word = rd_hit_ff ? rd_data_ff : rd_const_ff;

endmodule

>>> rtl/ramdac_register_interface_core.sv
// Top level of the palette DAC register interface with PLL register file.
//
// Usage: each req_ transaction is one CPU read (req_kind=0) or write (req_kind=1)
// on select {req_rs_high, req_addr_low}. Every transaction yields exactly one
// rsp_ transaction: read byte (0xff on writes), a palette-forward flag, the
// current pixel depth and a flag set when the command byte was written.
// A transaction reads the PLL store when accepted; its response is registered
// as the transaction leaves the execute state, once the output register is free.
// Transactions never overlap: the PLL store read and the read-modify-write
// that follows it complete before the next transaction is accepted.
// req_ready is high only in the idle state. The response register decouples
// the sides: if rsp_ready is low, the next transaction is still accepted and
// processed up to the point of loading the response, then waits there.
// Reset (synchronous) clears the unlock counter, indexes, phase, command byte,
// depth and the PLL valid bits; csr registers return to variant 4, vendor 1.
// csr_ writes take effect at once; the user must make them only while idle.
module ramdac_register_interface_core (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic       req_kind,
   input  logic [1:0] req_addr_low,
   input  logic       req_rs_high,
   input  logic [7:0] req_write_data,
   input  logic [7:0] req_palette_read_data,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_read_data,
   output logic       rsp_forwarded,
   output logic [2:0] rsp_pixel_depth,
   output logic       rsp_depth_updated,
   input  logic       csr_write_enable,
   input  logic       csr_index,
   input  logic [2:0] csr_write_data
);
   import rdac_pkg::*;

   typedef enum logic [1:0] {
      S_IDLE = 2'b01,
      S_EXEC = 2'b10
   } state_type;

   state_type   state_ff, state_in;

   // configuration
   logic [2:0]  variant_ff;
   logic        vendor_ff;

   // architectural state
   logic [2:0]  unlock_ff, unlock_in;
   logic [7:0]  wr_index_ff, wr_index_in;
   logic [7:0]  rd_index_ff, rd_index_in;
   logic        phase_ff, phase_in;
   logic [7:0]  command_ff, command_in;
   logic [2:0]  depth_ff, depth_in;

   // latched transaction
   logic        kind_ff;
   logic [2:0]  sel_ff;
   logic [7:0]  wdata_ff;
   logic [7:0]  pdata_ff;

   // response register
   logic        rsp_valid_ff;
   logic [7:0]  rsp_data_ff, rsp_data_in;
   logic        rsp_fwd_ff, rsp_fwd_in;
   logic        rsp_upd_ff, rsp_upd_in;

   logic        accept;
   logic        done;
   logic [15:0] pll_word;
   logic [15:0] pll_wr_word;
   logic        pll_wr_en;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   // finish when the response register can take the result
   assign done      = (state_ff == S_EXEC) && (!rsp_valid_ff || rsp_ready);

   // PLL store: read in the accept cycle at the index this access uses,
   // written back when the transaction completes.
   rdac_pll_store u_pll (
      .clock    (clock),
      .reset    (reset),
      .rd_en    (accept),
      .rd_index (req_kind ? wr_index_ff : rd_index_ff),
      .wr_en    (pll_wr_en),
      .wr_index (wr_index_ff),
      .wr_data  (pll_wr_word),
      .rd_word  (pll_word)
   );

   // byte merge for a data-port write; low byte first
   assign pll_wr_word = phase_ff ? {wdata_ff, pll_word[7:0]} : {pll_word[15:8], wdata_ff};
   assign pll_wr_en   = done && kind_ff && (sel_ff == SEL_PLL_DATA);

   always_comb begin
      unlock_in   = (sel_ff == SEL_HIDDEN) ? unlock_ff : 3'd0;
      wr_index_in = wr_index_ff;
      rd_index_in = rd_index_ff;
      phase_in    = phase_ff;
      command_in  = command_ff;
      depth_in    = depth_ff;
      rsp_data_in = WRITE_RESPONSE;
      rsp_fwd_in  = 1'b0;
      rsp_upd_in  = 1'b0;

      if (kind_ff) begin
         case (sel_ff)
            SEL_HIDDEN: begin
               if (unlock_ff == UNLOCK_OPEN) begin
                  command_in = wdata_ff;
                  depth_in   = depth_decode(variant_ff, wdata_ff, depth_ff);
                  rsp_upd_in = 1'b1;
                  unlock_in  = 3'd0;
               end else begin
                  rsp_fwd_in = 1'b1;
               end
            end
            SEL_PLL_WRITE_INDEX: begin
               wr_index_in = wdata_ff;
               phase_in    = 1'b0;
            end
            SEL_PLL_DATA: begin
               phase_in = ~phase_ff;
               if (phase_ff) begin
                  wr_index_in = wr_index_ff + 8'd1;
               end
            end
            SEL_COMMAND: begin
               command_in = wdata_ff;
               depth_in   = depth_decode(variant_ff, wdata_ff, depth_ff);
               rsp_upd_in = 1'b1;
            end
            SEL_PLL_READ_INDEX: begin
               rd_index_in = wdata_ff;
               phase_in    = 1'b0;
            end
            default: begin
               rsp_fwd_in = 1'b1;
            end
         endcase
      end else begin
         case (sel_ff)
            SEL_HIDDEN: begin
               if ((unlock_ff == UNLOCK_ONE) || (unlock_ff == UNLOCK_TWO)) begin
                  rsp_data_in = 8'h00;
                  unlock_in   = unlock_ff + 3'd1;
               end else if (unlock_ff == UNLOCK_THREE) begin
                  rsp_data_in = vendor_ff ? VENDOR_BYTE : 8'h00;
                  unlock_in   = unlock_ff + 3'd1;
               end else if (unlock_ff == UNLOCK_OPEN) begin
                  rsp_data_in = command_ff;
                  unlock_in   = 3'd0;
               end else begin
                  // locked, or one of the unreachable counts: plain palette read
                  rsp_data_in = pdata_ff;
                  rsp_fwd_in  = 1'b1;
                  unlock_in   = unlock_ff + 3'd1;
               end
            end
            SEL_PLL_WRITE_INDEX: rsp_data_in = wr_index_ff;
            SEL_PLL_DATA: begin
               rsp_data_in = phase_ff ? pll_word[15:8] : pll_word[7:0];
               phase_in    = ~phase_ff;
               if (phase_ff) begin
                  rd_index_in = rd_index_ff + 8'd1;
               end
            end
            SEL_COMMAND:        rsp_data_in = command_ff;
            SEL_PLL_READ_INDEX: rsp_data_in = rd_index_ff;
            default: begin
               rsp_data_in = pdata_ff;
               rsp_fwd_in  = 1'b1;
            end
         endcase
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE:  if (accept) state_in = S_EXEC;
         S_EXEC:  if (done) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         variant_ff   <= 3'd4;
         vendor_ff    <= 1'b1;
         unlock_ff    <= 3'd0;
         wr_index_ff  <= 8'd0;
         rd_index_ff  <= 8'd0;
         phase_ff     <= 1'b0;
         command_ff   <= 8'd0;
         depth_ff     <= 3'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_write_enable) begin
            case (csr_index)
               CSR_CHIP_VARIANT: variant_ff <= csr_write_data;
               CSR_VENDOR_ID:    vendor_ff  <= csr_write_data[0];
               default: ;
            endcase
         end
         if (done) begin
            unlock_ff    <= unlock_in;
            wr_index_ff  <= wr_index_in;
            rd_index_ff  <= rd_index_in;
            phase_ff     <= phase_in;
            command_ff   <= command_in;
            depth_ff     <= depth_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         kind_ff  <= req_kind;
         sel_ff   <= {req_rs_high, req_addr_low};
         wdata_ff <= req_write_data;
         pdata_ff <= req_palette_read_data;
      end
      if (done) begin
         rsp_data_ff <= rsp_data_in;
         rsp_fwd_ff  <= rsp_fwd_in;
         rsp_upd_ff  <= rsp_upd_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_read_data     = rsp_data_ff;
   assign rsp_forwarded     = rsp_fwd_ff;
   assign rsp_depth_updated = rsp_upd_ff;
   // depth is sampled with the response, so it reflects this transaction
   assign rsp_pixel_depth   = depth_ff;

endmodule

>>> rtl/rdac_checker.sv
// Port-level checker of the palette DAC register interface and its bind.
module rdac_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_read_data,
   input logic       rsp_forwarded,
   input logic [2:0] rsp_pixel_depth,
   input logic       rsp_depth_updated
);

   // a stalled response stays valid and holds its read data
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_read_data))
      else $error("response changed while stalled");

   // a command write returns the write response byte
   a_upd_write: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_depth_updated |-> rsp_read_data == 8'hff)
      else $error("command update without write response");

   // a command write never reaches the palette
   a_upd_local: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_depth_updated |-> !rsp_forwarded)
      else $error("command update forwarded");

   // depth stays within the defined codes
   a_depth_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_pixel_depth <= 3'd4)
      else $error("pixel depth out of range");

endmodule

bind ramdac_register_interface_core rdac_checker u_rdac_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_read_data     (rsp_read_data),
   .rsp_forwarded     (rsp_forwarded),
   .rsp_pixel_depth   (rsp_pixel_depth),
   .rsp_depth_updated (rsp_depth_updated)
);

>>> tb/tb_top.sv
// Self-checking testbench for the palette DAC register interface with PLL register file.
module tb_top;
   import rdac_pkg::*;

   // Palette-side selects: the block passes these through without decoding them.
   localparam logic [2:0] SEL_PAL_WRITE_ADDR = 3'd0;
   localparam logic [2:0] SEL_PAL_DATA       = 3'd1;
   localparam logic [2:0] SEL_PAL_READ_ADDR  = 3'd3;
   localparam logic [2:0] UNLOCK_CLOSED      = 3'd0;
   localparam int         WATCHDOG_LIMIT     = 2000;

   typedef enum logic {ACC_READ = 1'b0, ACC_WRITE = 1'b1} access_kind_type;

   typedef struct packed {
      access_kind_type kind;
      logic [2:0]      sel;
      logic [7:0]      wdata;
      logic [7:0]      pdata;
   } bus_access_type;

   typedef struct packed {
      logic [7:0] rdata;
      logic       fwd;
      logic [2:0] depth;
      logic       upd;
   } bus_reply_type;

   // Pixel depth by command byte: top three bits (early variants), top four bits (later ones).
   localparam logic [2:0] TOP3_DEPTH [8]  = '{3'd0, 3'd1, 3'd3, 3'd2, 3'd1, 3'd1, 3'd2, 3'd3};
   localparam logic [2:0] TOP4_DEPTH [16] = '{3'd0, 3'd0, 3'd1, 3'd1, 3'd3, 3'd2, 3'd2, 3'd4,
                                             3'd1, 3'd3, 3'd1, 3'd0, 3'd2, 3'd0, 3'd3, 3'd0};
   // PLL words that accept writes; everything else is read-only.
   localparam logic [7:0] PLL_RW_INDEX [8] = '{8'h02, 8'h03, 8'h04, 8'h05,
                                              8'h06, 8'h07, 8'h0a, 8'h0e};

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic       req_kind = 1'b0;
   logic [1:0] req_addr_low = 2'd0;
   logic       req_rs_high = 1'b0;
   logic [7:0] req_write_data = 8'd0;
   logic [7:0] req_palette_read_data = 8'd0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [7:0] rsp_read_data;
   logic       rsp_forwarded;
   logic [2:0] rsp_pixel_depth;
   logic       rsp_depth_updated;
   logic       csr_write_enable = 1'b0;
   logic       csr_index = 1'b0;
   logic [2:0] csr_write_data = 3'd0;

   // Predictor copy of the block state and its CSRs
   logic [15:0] pll_mem [256];
   logic [2:0]  unlock_cnt = UNLOCK_CLOSED;
   logic [7:0]  pll_wr_idx = 8'd0;
   logic [7:0]  pll_rd_idx = 8'd0;
   logic        byte_hi = 1'b0;
   logic [7:0]  command_reg = 8'd0;
   logic [2:0]  depth_reg = 3'd0;
   logic [2:0]  variant_cfg = VARIANT_LAST_KNOWN;
   logic        vendor_cfg = 1'b1;

   bus_access_type pending_q [$];   // transactions not yet presented
   bus_reply_type  reply_q [$];     // predicted responses, oldest first
   bus_access_type cur_access;
   bus_access_type nxt_access;
   bus_reply_type  want;
   int             tx_idle_pct = 0;
   int             rx_idle_pct = 0;
   int             error_count = 0;
   int             stall_cycles = 0;

   ramdac_register_interface_core u_dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_kind              (req_kind),
      .req_addr_low          (req_addr_low),
      .req_rs_high           (req_rs_high),
      .req_write_data        (req_write_data),
      .req_palette_read_data (req_palette_read_data),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_read_data         (rsp_read_data),
      .rsp_forwarded         (rsp_forwarded),
      .rsp_pixel_depth       (rsp_pixel_depth),
      .rsp_depth_updated     (rsp_depth_updated),
      .csr_write_enable      (csr_write_enable),
      .csr_index             (csr_index),
      .csr_write_data        (csr_write_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Command write: unknown variants keep the old depth but still store the byte.
   function automatic void load_command(input logic [7:0] v);
      command_reg = v;
      if (variant_cfg <= VARIANT_LAST_THREE_BIT) begin
         depth_reg = TOP3_DEPTH[v[7:5]];
      end else if (variant_cfg <= VARIANT_LAST_KNOWN) begin
         depth_reg = TOP4_DEPTH[v[7:4]];
      end
   endfunction

   // Applies one bus access to the predictor state and returns the response it must produce.
   function automatic bus_reply_type predict_access(input bus_access_type a);
      bus_reply_type r;
      logic [15:0] w;
      r.rdata = WRITE_RESPONSE;
      r.fwd   = 1'b0;
      r.upd   = 1'b0;
      // anything off select 2 breaks the hidden unlock sequence
      if (a.sel != SEL_HIDDEN) begin
         unlock_cnt = UNLOCK_CLOSED;
      end
      if (a.kind == ACC_WRITE) begin
         case (a.sel)
            SEL_HIDDEN: begin
               if (unlock_cnt == UNLOCK_OPEN) begin
                  load_command(a.wdata);
                  r.upd = 1'b1;
                  unlock_cnt = UNLOCK_CLOSED;
               end else begin
                  r.fwd = 1'b1;   // count is left alone
               end
            end
            SEL_PLL_WRITE_INDEX: begin
               pll_wr_idx = a.wdata;
               byte_hi = 1'b0;
            end
            SEL_PLL_DATA: begin
               if ((pll_wr_idx >= 8'h02 && pll_wr_idx <= 8'h07) ||
                   pll_wr_idx == 8'h0a || pll_wr_idx == 8'h0e) begin
                  w = pll_mem[pll_wr_idx];
                  if (byte_hi) begin
                     w[15:8] = a.wdata;
                  end else begin
                     w[7:0] = a.wdata;
                  end
                  pll_mem[pll_wr_idx] = w;
               end
               // phase and index move even when the byte is dropped
               if (byte_hi) begin
                  pll_wr_idx = pll_wr_idx + 8'd1;
               end
               byte_hi = ~byte_hi;
            end
            SEL_COMMAND: begin
               load_command(a.wdata);
               r.upd = 1'b1;
            end
            SEL_PLL_READ_INDEX: begin
               pll_rd_idx = a.wdata;
               byte_hi = 1'b0;
            end
            default: r.fwd = 1'b1;
         endcase
      end else begin
         case (a.sel)
            SEL_HIDDEN: begin
               if (unlock_cnt == UNLOCK_ONE || unlock_cnt == UNLOCK_TWO) begin
                  r.rdata = 8'h00;
                  unlock_cnt = unlock_cnt + 3'd1;
               end else if (unlock_cnt == UNLOCK_THREE) begin
                  r.rdata = vendor_cfg ? VENDOR_BYTE : 8'h00;
                  unlock_cnt = unlock_cnt + 3'd1;
               end else if (unlock_cnt == UNLOCK_OPEN) begin
                  r.rdata = command_reg;
                  unlock_cnt = UNLOCK_CLOSED;
               end else begin
                  r.rdata = a.pdata;
                  r.fwd = 1'b1;
                  unlock_cnt = unlock_cnt + 3'd1;
               end
            end
            SEL_PLL_WRITE_INDEX: r.rdata = pll_wr_idx;
            SEL_PLL_DATA: begin
               w = pll_mem[pll_rd_idx];
               r.rdata = byte_hi ? w[15:8] : w[7:0];
               if (byte_hi) begin
                  pll_rd_idx = pll_rd_idx + 8'd1;
               end
               byte_hi = ~byte_hi;
            end
            SEL_COMMAND: r.rdata = command_reg;
            SEL_PLL_READ_INDEX: r.rdata = pll_rd_idx;
            default: begin
               r.rdata = a.pdata;
               r.fwd = 1'b1;
            end
         endcase
      end
      r.depth = depth_reg;
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // Driver: presents queued transactions, holding each until accepted.
   // The prediction is taken at the acceptance edge, in transaction order.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            reply_q.push_back(predict_access(cur_access));
         end
         // Slot is free when nothing is held or the held one just went in
         if (!req_valid || req_ready) begin
            if (pending_q.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
               nxt_access = pending_q.pop_front();
               cur_access <= nxt_access;
               req_valid <= 1'b1;
               req_kind <= nxt_access.kind;
               req_addr_low <= nxt_access.sel[1:0];
               req_rs_high <= nxt_access.sel[2];
               req_write_data <= nxt_access.wdata;
               req_palette_read_data <= nxt_access.pdata;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Receiver backpressure, redrawn every cycle
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
   end

   // ---------------------------------------------------------------------
   // Monitor: every response transaction is checked against the oldest
   // prediction, field by field.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (reply_q.size() == 0) begin
            $error("response transaction with nothing outstanding: read_data %0h",
                   rsp_read_data);
            error_count <= error_count + 1;
         end else begin
            want = reply_q.pop_front();
            if (rsp_read_data !== want.rdata ||
                rsp_forwarded !== want.fwd ||
                rsp_pixel_depth !== want.depth ||
                rsp_depth_updated !== want.upd) begin
               error_count <= error_count + 1;
            end
            if (rsp_read_data !== want.rdata) begin
               $error("read_data: expected %0h, got %0h", want.rdata, rsp_read_data);
            end
            if (rsp_forwarded !== want.fwd) begin
               $error("forwarded: expected %0d, got %0d", want.fwd, rsp_forwarded);
            end
            if (rsp_pixel_depth !== want.depth) begin
               $error("pixel_depth: expected %0d, got %0d", want.depth, rsp_pixel_depth);
            end
            if (rsp_depth_updated !== want.upd) begin
               $error("depth_updated: expected %0d, got %0d", want.upd, rsp_depth_updated);
            end
         end
      end
   end

   // Watchdog: too long without any transaction on either side ends the run
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------
   task automatic add_access(input access_kind_type kind, input logic [2:0] sel,
                             input logic [7:0] wdata, input logic [7:0] pdata);
      bus_access_type a;
      a.kind  = kind;
      a.sel   = sel;
      a.wdata = wdata;
      a.pdata = pdata;
      pending_q.push_back(a);
   endtask

   task automatic add_read(input logic [2:0] sel);
      add_access(ACC_READ, sel, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
   endtask

   task automatic add_write(input logic [2:0] sel, input logic [7:0] wdata);
      add_access(ACC_WRITE, sel, wdata, 8'($urandom_range(0, 255)));
   endtask

   // CSR write; the predictor takes the new value at once since the block is idle
   task automatic write_csr(input logic idx, input logic [2:0] data);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= data;
      if (idx == CSR_CHIP_VARIANT) begin
         variant_cfg = data;
      end else begin
         vendor_cfg = data[0];
      end
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // Everything presented, accepted and answered
   task automatic wait_drained();
      while (pending_q.size() != 0 || req_valid || reply_q.size() != 0) begin
         @(negedge clock);
      end
   endtask

   // Short directed pass over field extremes, every select and the corner cases
   task automatic queue_directed();
      add_access(ACC_READ, SEL_PAL_WRITE_ADDR, 8'h00, 8'h00);
      add_access(ACC_READ, SEL_PAL_DATA, 8'hff, 8'hff);
      add_access(ACC_WRITE, SEL_PAL_READ_ADDR, 8'h00, 8'ha5);
      add_read(SEL_PLL_DATA);                  // power-up word 0, low then high
      add_read(SEL_PLL_DATA);
      add_write(SEL_PLL_WRITE_INDEX, 8'h0e);   // last writable word
      add_write(SEL_PLL_DATA, 8'hff);
      add_write(SEL_PLL_DATA, 8'h00);
      add_write(SEL_PLL_READ_INDEX, 8'h0e);
      add_read(SEL_PLL_DATA);
      add_read(SEL_PLL_READ_INDEX);
      add_write(SEL_PLL_WRITE_INDEX, 8'hff);   // read-only word, index wraps to 0
      add_write(SEL_PLL_DATA, 8'h12);
      add_write(SEL_PLL_DATA, 8'h34);
      add_read(SEL_PLL_WRITE_INDEX);
      // hidden unlock: four select-2 reads, then the command byte opens up
      add_access(ACC_READ, SEL_HIDDEN, 8'h00, 8'h5a);
      add_read(SEL_HIDDEN);
      add_read(SEL_HIDDEN);
      add_read(SEL_HIDDEN);
      add_write(SEL_HIDDEN, 8'hf0);
      add_write(SEL_HIDDEN, 8'h3c);            // locked write goes to the palette
      add_write(SEL_COMMAND, 8'h70);           // 32 bpp on the four-bit decode
      add_read(SEL_COMMAND);
   endtask

   // Random traffic built mostly from well-formed sequences with random content
   task automatic queue_random(input int n_items);
      int          stop_at;
      int          choice;
      int          burst;
      logic [7:0]  idx;
      stop_at = pending_q.size() + n_items;
      while (pending_q.size() < stop_at) begin
         choice = $urandom_range(0, 99);
         if (choice < 25) begin
            // unlock sequence, sometimes broken by a stray access
            for (int k = 0; k < 4; k++) begin
               if ($urandom_range(0, 9) == 0) begin
                  if ($urandom_range(0, 1) == 0) begin
                     add_write(SEL_HIDDEN, 8'($urandom_range(0, 255)));
                  end else begin
                     add_read(3'($urandom_range(0, 7)));
                  end
               end
               add_read(SEL_HIDDEN);
            end
            if ($urandom_range(0, 1) == 0) begin
               add_write(SEL_HIDDEN, 8'($urandom_range(0, 255)));
            end else begin
               add_read(SEL_HIDDEN);
            end
         end else if (choice < 45) begin
            // PLL write burst, optionally read back
            idx = ($urandom_range(0, 4) != 0) ? PLL_RW_INDEX[3'($urandom_range(0, 7))]
                                              : 8'($urandom_range(0, 255));
            burst = $urandom_range(1, 4);
            add_write(SEL_PLL_WRITE_INDEX, idx);
            for (int k = 0; k < burst; k++) begin
               add_write(SEL_PLL_DATA, 8'($urandom_range(0, 255)));
            end
            if ($urandom_range(0, 1) == 0) begin
               add_write(SEL_PLL_READ_INDEX, idx);
               for (int k = 0; k < burst; k++) begin
                  add_read(SEL_PLL_DATA);
               end
            end
         end else if (choice < 55) begin
            add_write(SEL_COMMAND, 8'($urandom_range(0, 255)));
            add_read(SEL_COMMAND);
         end else if (choice < 70) begin
            // PLL read burst; indexes near the top exercise the wrap
            idx = ($urandom_range(0, 2) == 0) ? 8'($urandom_range(254, 255))
                                              : 8'($urandom_range(0, 255));
            add_write(SEL_PLL_READ_INDEX, idx);
            burst = $urandom_range(2, 6);
            for (int k = 0; k < burst; k++) begin
               add_read(SEL_PLL_DATA);
            end
            add_read(SEL_PLL_READ_INDEX);
            add_read(SEL_PLL_WRITE_INDEX);
         end else begin
            // noise: any kind, any select
            add_access(access_kind_type'($urandom_range(0, 1)), 3'($urandom_range(0, 7)),
                       8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
         end
      end
   endtask

   // One phase: drain, reprogram the CSRs, set the idle mix, queue the traffic.
   // The drain is also where the sender holds off until all responses are back.
   task automatic run_phase(input logic [2:0] variant, input logic vendor,
                            input int tx_pct, input int rx_pct, input int n_items);
      wait_drained();
      write_csr(CSR_CHIP_VARIANT, variant);
      write_csr(CSR_VENDOR_ID, {2'b00, vendor});
      @(negedge clock);
      tx_idle_pct = tx_pct;
      rx_idle_pct = rx_pct;
      if (n_items == 0) begin
         queue_directed();
      end else begin
         queue_random(n_items);
      end
   endtask

   initial begin
      for (int i = 0; i < 256; i++) begin
         pll_mem[i] = 16'h0000;
      end
      pll_mem[0] = PLL_WORD0_INIT;
      pll_mem[1] = PLL_WORD1_INIT;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // sender sparse-idle / receiver heavy-stall
      run_phase(VARIANT_LAST_KNOWN, 1'b1, 26, 78, 0);
      run_phase(3'd0, 1'b0, 26, 78, 130);
      run_phase(VARIANT_LAST_THREE_BIT, 1'b1, 26, 78, 130);
      // roles swapped
      run_phase(3'd2, 1'b0, 78, 26, 130);
      run_phase(3'd3, 1'b1, 78, 26, 130);
      // full rate, including variants the depth decode does not know
      run_phase(3'd7, 1'b1, 0, 0, 60);
      run_phase(3'd5, 1'b0, 0, 0, 60);
      run_phase(VARIANT_LAST_KNOWN, 1'b1, 0, 0, 160);

      wait_drained();
      repeat (4) @(posedge clock);
      if (error_count == 0 && reply_q.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
